@@ hdl/array_sort_median_statistics_unit_assert.svh @@
// Assertion macros for the sort/statistics unit checker.
// Used by asmsu_checker; no other dependencies.
`ifndef ARRAY_SORT_MEDIAN_STATISTICS_UNIT_ASSERT_SVH
`define ARRAY_SORT_MEDIAN_STATISTICS_UNIT_ASSERT_SVH

// same-cycle implication
`define ASMSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASMSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/asmsu_pkg.sv @@
// Shared constants, types and command/status structs of the sort/statistics unit.
// No dependencies.
`default_nettype none

package asmsu_pkg;

  localparam int MaxCount = 64;
  localparam int CntW     = $clog2(MaxCount + 1);
  localparam int IdxW     = $clog2(MaxCount);
  localparam int ValW     = 8;
  localparam int PosW     = 6;
  localparam int SumW     = 14;
  localparam int DivCntW  = $clog2(SumW);
  localparam int OutDataW = 48;

  typedef enum logic [4:0] {
    StLoad = 5'b00001,
    StSort = 5'b00010,
    StScan = 5'b00100,
    StWait = 5'b01000,
    StEmit = 5'b10000
  } state_e;

  typedef struct packed {
    logic            load;
    logic            clear;
    logic            sort_en;
    logic            rotate;
    logic            scan_en;
    logic            div_start;
    logic [IdxW-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            div_busy;
  } status_t;

endpackage

`default_nettype wire

@@ hdl/asmsu_ctrl.sv @@
// Controller FSM: load, sort passes, median scan, divider wait, emit.
// Depends on asmsu_pkg.
`default_nettype none

module asmsu_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  input  wire logic              s_last_i,
  output logic                   s_ready_o,
  output logic                   m_valid_o,
  input  wire logic              m_ready_i,
  input  wire asmsu_pkg::status_t status_i,
  output asmsu_pkg::cmd_t        cmd_o
);
  import asmsu_pkg::*;

  state_e          state_q, state_d;
  logic [IdxW-1:0] step_q, step_d;
  logic            last;

  assign last = (CntW'(step_q) == status_i.count - CntW'(1));

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    cmd_o         = '0;
    cmd_o.step    = step_q;
    unique case (state_q)
      StLoad: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          if (s_last_i) state_d = StSort;
        end
      end
      StSort: begin
        cmd_o.sort_en   = 1'b1;
        cmd_o.div_start = (step_q == '0);
        if (last) begin
          step_d  = '0;
          state_d = StScan;
        end else begin
          step_d = step_q + IdxW'(1);
        end
      end
      StScan: begin
        cmd_o.rotate  = 1'b1;
        cmd_o.scan_en = 1'b1;
        if (last) begin
          step_d  = '0;
          state_d = StWait;
        end else begin
          step_d = step_q + IdxW'(1);
        end
      end
      StWait: begin
        if (!status_i.div_busy) state_d = StEmit;
      end
      StEmit: begin
        if (m_ready_i) begin
          cmd_o.rotate = 1'b1;
          if (last) begin
            cmd_o.clear = 1'b1;
            step_d      = '0;
            state_d     = StLoad;
          end else begin
            step_d = step_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = StLoad;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign s_ready_o = (state_q == StLoad);
  assign m_valid_o = (state_q == StEmit);

endmodule

`default_nettype wire

@@ hdl/asmsu_div.sv @@
// Restoring divider, one quotient bit per cycle: running sum / element count.
// Depends on asmsu_pkg.
`default_nettype none

module asmsu_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [asmsu_pkg::SumW-1:0] dividend_i,
  input  wire logic [asmsu_pkg::CntW-1:0] divisor_i,
  output logic                            busy_o,
  output logic [asmsu_pkg::ValW-1:0]      quotient_o
);
  import asmsu_pkg::*;

  logic               busy_q;
  logic [DivCntW-1:0] cnt_q;
  logic [SumW-1:0]    quo_q;
  logic [CntW-1:0]    rem_q;
  logic [CntW-1:0]    div_q;
  logic [CntW:0]      trial;
  logic               fits;

  assign trial = {rem_q, quo_q[SumW-1]};
  assign fits  = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DivCntW'(SumW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SumW-2:0], fits};
      rem_q <= fits ? CntW'(trial - {1'b0, div_q}) : CntW'(trial);
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q[ValW-1:0];

endmodule

`default_nettype wire

@@ hdl/asmsu_datapath.sv @@
// Datapath: shift-in cell row with odd-even transposition sort, rotation ring,
// count/sum/min/max/median registers. Depends on asmsu_pkg.
`default_nettype none

module asmsu_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire asmsu_pkg::cmd_t            cmd_i,
  input  wire logic [asmsu_pkg::ValW-1:0] sample_i,
  output logic [asmsu_pkg::CntW-1:0]      count_o,
  output logic [asmsu_pkg::SumW-1:0]      sum_o,
  output logic [asmsu_pkg::ValW-1:0]      head_o,
  output logic [asmsu_pkg::ValW-1:0]      median_o,
  output logic [asmsu_pkg::ValW-1:0]      maximum_o,
  output logic [asmsu_pkg::ValW-1:0]      minimum_o,
  output logic                            dropped_o
);
  import asmsu_pkg::*;

  logic [ValW-1:0]     cell_q [MaxCount];
  logic [ValW-1:0]     cell_d [MaxCount];
  logic [MaxCount-1:0] vld_q, vld_d;
  logic [MaxCount-2:0] swap;

  logic [CntW-1:0] count_q;
  logic [SumW-1:0] sum_q;
  logic            ovf_q;
  logic [ValW-1:0] max_q, min_q, med_a_q, median_q;
  logic            room, load_en;
  logic            lo_hit, hi_hit;
  logic [ValW:0]   med_sum;

  assign room    = (count_q < CntW'(MaxCount));
  assign load_en = cmd_i.load && room;

  // compare-exchange between cell j and j+1, descending, empty cells lowest
  for (genvar j = 0; j < MaxCount - 1; j++) begin : g_swap
    assign swap[j] = cmd_i.sort_en && (1'(j) == cmd_i.step[0]) &&
                     ({vld_q[j], cell_q[j]} < {vld_q[j+1], cell_q[j+1]});
  end

  for (genvar i = 0; i < MaxCount; i++) begin : g_cell
    logic [ValW-1:0] lo_v, hi_v;
    logic            lo_b, hi_b, sw_up, sw_dn, wrap;

    if (i == 0) begin : g_first
      assign lo_v  = sample_i;
      assign lo_b  = 1'b1;
      assign sw_dn = 1'b0;
    end else begin : g_inner_lo
      assign lo_v  = cell_q[i-1];
      assign lo_b  = vld_q[i-1];
      assign sw_dn = swap[i-1];
    end

    if (i == MaxCount - 1) begin : g_last
      assign hi_v  = cell_q[i];
      assign hi_b  = vld_q[i];
      assign sw_up = 1'b0;
    end else begin : g_inner_hi
      assign hi_v  = cell_q[i+1];
      assign hi_b  = vld_q[i+1];
      assign sw_up = swap[i];
    end

    assign wrap = (CntW'(i) == count_q - CntW'(1));

    always_comb begin
      cell_d[i] = cell_q[i];
      vld_d[i]  = vld_q[i];
      priority if (load_en) begin
        cell_d[i] = lo_v;
        vld_d[i]  = lo_b;
      end else if (cmd_i.clear) begin
        vld_d[i] = 1'b0;
      end else if (sw_up) begin
        cell_d[i] = hi_v;
        vld_d[i]  = hi_b;
      end else if (sw_dn) begin
        cell_d[i] = lo_v;
        vld_d[i]  = lo_b;
      end else if (cmd_i.rotate) begin
        cell_d[i] = wrap ? cell_q[0] : hi_v;
      end else begin
        cell_d[i] = cell_q[i];
        vld_d[i]  = vld_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= vld_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.load) begin
      if (room) begin
        count_q <= count_q + CntW'(1);
        sum_q   <= sum_q + SumW'(sample_i);
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      if (count_q == '0 || sample_i > max_q) max_q <= sample_i;
      if (count_q == '0 || sample_i < min_q) min_q <= sample_i;
    end
  end

  // median: catch the middle element(s) as the ring passes cell 0
  assign lo_hit  = (CntW'(cmd_i.step) == ((count_q - CntW'(1)) >> 1));
  assign hi_hit  = (CntW'(cmd_i.step) == (count_q >> 1));
  assign med_sum = {1'b0, lo_hit ? cell_q[0] : med_a_q} + {1'b0, cell_q[0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en) begin
      if (lo_hit) med_a_q  <= cell_q[0];
      if (hi_hit) median_q <= med_sum[ValW:1];
    end
  end

  assign count_o   = count_q;
  assign sum_o     = sum_q;
  assign head_o    = cell_q[0];
  assign median_o  = median_q;
  assign maximum_o = max_q;
  assign minimum_o = min_q;
  assign dropped_o = ovf_q;

endmodule

`default_nettype wire

@@ hdl/array_sort_median_statistics_unit.sv @@
// Top level of the descending sort unit with median, mean, max and min.
// Instantiates asmsu_ctrl, asmsu_datapath, asmsu_div; depends on asmsu_pkg.
//
// channel  dir  handshake          payload
// s_axis   in   tvalid / tready    tdata = sample, tlast = final_req
// m_axis   out  tvalid / tready    tdata = sorted_value..minimum, tlast = run_end,
//                                  tuser = dropped
//
// Loading takes one request per cycle. After the closing request the set of n
// elements passes through the transposition sort and then the median scan of
// the cell ring; the first result also waits for the serial divider (mean).
// Results then leave one per cycle while m_axis_tready is high; input is held
// off until the last result is taken.
// Reset (async, active low) clears count, sum, flags and cell valid bits.
`default_nettype none

module array_sort_median_statistics_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [7:0]                     s_axis_tdata_i,  // [7:0] sample
  input  wire logic                           s_axis_tlast_i,  // final_req
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // [7:0] sorted_value, [13:8] position, [21:14] median, [29:22] mean,
  // [37:30] maximum, [45:38] minimum, [47:46] zero
  output logic [asmsu_pkg::OutDataW-1:0]      m_axis_tdata_o,
  output logic                                m_axis_tlast_o,  // run_end
  output logic                                m_axis_tuser_o   // dropped
);
  import asmsu_pkg::*;

  cmd_t            cmd;
  status_t         status;
  logic [CntW-1:0] count;
  logic [SumW-1:0] sum;
  logic [ValW-1:0] head, median, mean, maximum, minimum;
  logic            dropped, div_busy;

  assign status.count    = count;
  assign status.div_busy = div_busy;

  asmsu_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_last_i  (s_axis_tlast_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  asmsu_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sample_i  (s_axis_tdata_i),
    .count_o   (count),
    .sum_o     (sum),
    .head_o    (head),
    .median_o  (median),
    .maximum_o (maximum),
    .minimum_o (minimum),
    .dropped_o (dropped)
  );

  asmsu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd.div_start),
    .dividend_i (sum),
    .divisor_i  (count),
    .busy_o     (div_busy),
    .quotient_o (mean)
  );

  assign m_axis_tdata_o = {2'b00, minimum, maximum, mean, median, PosW'(cmd.step), head};
  assign m_axis_tlast_o = (CntW'(cmd.step) == count - CntW'(1));
  assign m_axis_tuser_o = dropped;

endmodule

`default_nettype wire

@@ hdl/asmsu_checker.sv @@
// Port-level checker for array_sort_median_statistics_unit, bound to the top.
// Uses macros from array_sort_median_statistics_unit_assert.svh.
`default_nettype none
`include "array_sort_median_statistics_unit_assert.svh"

module asmsu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [47:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o,
  input wire logic        m_axis_tuser_o
);

  logic        out_go, out_end, out_mid;
  logic [32:0] stat_w;
  logic [7:0]  value_w;
  logic [5:0]  pos_w;

  assign out_go  = m_axis_tvalid_o && m_axis_tready_i;
  assign out_end = out_go && m_axis_tlast_o;
  assign out_mid = out_go && !m_axis_tlast_o;
  assign stat_w  = {m_axis_tuser_o, m_axis_tdata_o[45:14]};
  assign value_w = m_axis_tdata_o[7:0];
  assign pos_w   = m_axis_tdata_o[13:8];

  `ASMSU_ASSERT_NOW(a_one_side, s_axis_tready_o, !m_axis_tvalid_o, "load and emit overlap")
  `ASMSU_ASSERT_NEXT(a_run_closes, out_end, !m_axis_tvalid_o, "result after run end")
  `ASMSU_ASSERT_NEXT(a_stats_hold, out_mid, m_axis_tvalid_o && $stable(stat_w), "stats changed")
  `ASMSU_ASSERT_NEXT(a_descending, out_mid, value_w <= $past(value_w), "results not descending")
  `ASMSU_ASSERT_NOW(a_first_pos, $rose(m_axis_tvalid_o), pos_w == 6'd0, "run not at position 0")

endmodule

bind array_sort_median_statistics_unit asmsu_checker u_asmsu_checker (.*);

`default_nettype wire
